// File: rtl/rebd_pkg.sv
// Shared types, constants and codes of the rotary encoder and button decoder.
`default_nettype none
package rebd_pkg;

	localparam int CNT_W = 16;
	localparam int CFG_W = 16;
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(100);
	localparam logic [CFG_W-1:0] STUCK_RESET    = CFG_W'(60000);

	typedef enum logic [0:0] {
		REG_DEBOUNCE = 1'b0,
		REG_STUCK    = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE        = 3'd0,
		ST_BTN_DEB     = 3'd1,
		ST_BTN_HELD    = 3'd2,
		ST_FIRST_DEB   = 3'd3,
		ST_FIRST_HELD  = 3'd4,
		ST_SECOND_DEB  = 3'd5,
		ST_SECOND_HELD = 3'd6
	} state_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_LEFT  = 2'd1,
		EV_RIGHT = 2'd2,
		EV_PUSH  = 2'd3
	} event_t;

	localparam logic DIR_LEFT  = 1'b0;
	localparam logic DIR_RIGHT = 1'b1;

	// One tick's pin sample, active low.
	typedef struct packed {
		logic phase_b_n;
		logic phase_a_n;
		logic button_n;
	} pins_t;

	// Result of one tick.
	typedef struct packed {
		logic   stuck;
		event_t event_code;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0] stuck_ticks;
		logic [CFG_W-1:0] debounce_ticks;
	} cfg_t;

endpackage
`default_nettype wire

// File: rtl/rebd_core.sv
// Debounce and quadrature decode state machine, one update per enabled tick.
`default_nettype none
module rebd_core import rebd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire pins_t   pins,
	input  wire cfg_t    cfg,
	output result_t      result
);

	state_t           state_q, state_d;
	logic             dir_q, dir_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             flag_q, flag_d;

	logic             btn, pa, pb, first, second;
	logic [CNT_W-1:0] cnt_inc;
	logic             at_max, deb_done, stuck_done;

	assign btn    = ~pins.button_n;
	assign pa     = ~pins.phase_a_n;
	assign pb     = ~pins.phase_b_n;
	assign first  = (dir_q == DIR_LEFT) ? pa : pb;
	assign second = (dir_q == DIR_LEFT) ? pb : pa;

	// Saturating advance; the all-ones count ends any wait.
	assign cnt_inc    = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + CNT_W'(1);
	assign at_max     = (cnt_inc == CNT_MAX);
	assign deb_done   = (CMP_W'(cnt_inc) >= CMP_W'(cfg.debounce_ticks)) || at_max;
	assign stuck_done = (CMP_W'(cnt_inc) >= CMP_W'(cfg.stuck_ticks)) || at_max;

	always_comb begin
		state_d = state_q;
		dir_d   = dir_q;
		cnt_d   = cnt_q;
		flag_d  = flag_q & ~(~pa & ~pb);
		case (state_q)
			ST_IDLE: begin
				if (btn) begin
					state_d = ST_BTN_DEB;
					cnt_d   = '0;
				end else if (!flag_d && (pa || pb)) begin
					dir_d   = pa ? DIR_LEFT : DIR_RIGHT;
					state_d = ST_FIRST_DEB;
					cnt_d   = '0;
				end
			end
			ST_BTN_DEB: begin
				cnt_d = cnt_inc;
				if (deb_done) state_d = btn ? ST_BTN_HELD : ST_IDLE;
			end
			ST_BTN_HELD: begin
				if (!btn) state_d = ST_IDLE;
			end
			ST_FIRST_DEB: begin
				cnt_d = cnt_inc;
				if (deb_done) state_d = first ? ST_FIRST_HELD : ST_IDLE;
			end
			ST_FIRST_HELD: begin
				if (!first) begin
					state_d = ST_IDLE;
				end else if (second) begin
					state_d = ST_SECOND_DEB;
					cnt_d   = '0;
				end
			end
			ST_SECOND_DEB: begin
				cnt_d = cnt_inc;
				if (deb_done) begin
					if (second) begin
						state_d = ST_SECOND_HELD;
						cnt_d   = '0;
					end else begin
						state_d = ST_FIRST_HELD;
					end
				end
			end
			ST_SECOND_HELD: begin
				if (!second) begin
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_inc;
					if (stuck_done) begin
						flag_d  = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		result.event_code = EV_NONE;
		result.stuck      = flag_d;
		case (state_q)
			ST_BTN_HELD: begin
				if (!btn) result.event_code = EV_PUSH;
			end
			ST_SECOND_HELD: begin
				if (!second || stuck_done)
					result.event_code = (dir_q == DIR_LEFT) ? EV_LEFT : EV_RIGHT;
			end
			default: result.event_code = EV_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dir_q   <= DIR_LEFT;
			cnt_q   <= '0;
			flag_q  <= 1'b0;
		end else if (en) begin
			state_q <= state_d;
			dir_q   <= dir_d;
			cnt_q   <= cnt_d;
			flag_q  <= flag_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/rotary_encoder_button_decoder_unit.sv
// Top level: sample register, decode state machine and result register.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata[2:0] = phase_b_n, phase_a_n, button_n
//  m_axis   | out       | tdata[2:0] = stuck, event_code[1:0]
//  cfg      | in        | cfg_index 0 debounce_ticks, 1 stuck_ticks
//
// A sample passes from the sample register through the single state update
// into the result register; one sample per cycle is taken while the output
// is not stalled. Reset puts the state machine in idle and loads the register
// defaults. A stalled output holds the result and the sample register, and
// s_axis_tready drops only when both are full.
`default_nettype none
module rotary_encoder_button_decoder_unit import rebd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [7:0]       s_axis_tdata,   // [0] button_n, [1] phase_a_n, [2] phase_b_n
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [7:0]            m_axis_tdata,   // [1:0] event_code, [2] stuck
	input  wire logic             cfg_we,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	pins_t   pins_s1;
	logic    valid_s1;
	result_t result_d;
	result_t result_s2;
	logic    valid_s2;
	logic    out_free, adv;

	assign out_free      = ~valid_s2 | m_axis_tready;
	assign adv           = valid_s1 & out_free;
	assign s_axis_tready = ~valid_s1 | out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DEBOUNCE_RESET;
			cfg_q.stuck_ticks    <= STUCK_RESET;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data;
				REG_STUCK:    cfg_q.stuck_ticks    <= cfg_data;
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) pins_s1 <= pins_t'(s_axis_tdata[2:0]);
	end

	rebd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.pins   (pins_s1),
		.cfg    (cfg_q),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) result_s2 <= result_d;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'b0, result_s2.stuck, result_s2.event_code};

`ifndef ASSERT_OFF
	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2))
		else $error("input stalled while a stage is empty");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(pins_s1)))
		else $error("stalled sample changed");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && m_axis_tready && !adv) |=> !m_axis_tvalid)
		else $error("result repeated after transaction");
`endif

endmodule
`default_nettype wire
